@@ rtl/lapid_pkg.sv @@
// ----------------------------------------------------------------------------
// lapid_pkg
// Types, widths and constants shared by the actuator PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lapid_pkg;

    localparam int POS_W   = 18;
    localparam int ERR_W   = 19;
    localparam int DIF_W   = 20;
    localparam int DRV_W   = 21;
    localparam int INT_W   = 32;
    localparam int SUM_W   = 36;
    localparam int DUTY_W  = 16;
    localparam int CAP_W   = 15;
    localparam int MS_W    = 16;
    localparam int RAW_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int LIM_W   = 31;
    localparam int PER_W   = 10;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 3;
    localparam int STAT_W  = 3;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 34;
    localparam int DIV_D_W = 16;
    localparam int TGT_W   = MUL_P_W - 16;

    localparam int unsigned DEF_ACTUATOR_LEN_UM = 200000;
    localparam int unsigned DEF_EMERGENCY_UM    = 2000;
    localparam int unsigned DEF_SAFE_UM         = 10000;
    localparam int unsigned DEF_SAFE_DUTY       = 9830;
    localparam int unsigned DEF_SLEW_PER_MS     = 64;
    localparam int unsigned DEF_TOLERANCE_UM    = 200;

    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(31785);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_MOVE   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_LOST      = 3'd1,
        ST_STOPPED   = 3'd2,
        ST_EMERGENCY = 3'd3,
        ST_SAFE      = 3'd4
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_ILIM    = 3'd3,
        REG_RAW_MIN = 3'd4,
        REG_RAW_MAX = 3'd5,
        REG_PERIOD  = 3'd6,
        REG_LOST    = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SMP_MUL,
        S_SMP_DIV,
        S_SMP_WAIT,
        S_T_IMUL,
        S_T_INT,
        S_T_P,
        S_T_I,
        S_T_DWAIT,
        S_T_DMUL,
        S_T_D,
        S_T_FIN,
        S_T_OUT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/lapid_if.sv @@
// ----------------------------------------------------------------------------
// lapid_if
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lapid_in_if import lapid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [RAW_W-1:0]        raw_sample;
    logic signed [ERR_W-1:0] target_um;
    logic [15:0]             power_limit;

    modport source (output valid, cmd, raw_sample, target_um, power_limit, input ready);
    modport sink   (input valid, cmd, raw_sample, target_um, power_limit, output ready);
endinterface

interface lapid_out_if import lapid_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DUTY_W-1:0] duty;
    logic                     dir_extend;
    logic                     dir_retract;
    logic [STAT_W-1:0]        status;

    modport source (output valid, duty, dir_extend, dir_retract, status, input ready);
    modport sink   (input valid, duty, dir_extend, dir_retract, status, output ready);
endinterface

`default_nettype wire

@@ rtl/linear_actuator_pid_with_safety_zones.sv @@
// Move, stop and any tick or sample that needs no arithmetic go from accept
// straight to the result beat; an in-range sample and a full control tick
// wait on the 34-step shared divider; the multiplier is shared by all products.
// One command in flight at a time; the next is taken while a result waits.
// rst_n sets configuration and control state at once to reset values: no clearing pass.
// ----------------------------------------------------------------------------
// linear_actuator_pid_with_safety_zones
// Position PID for a linear actuator with sensor timeout, end zones and
// duty slew, sequenced over one shared multiplier and one divider.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_actuator_pid_with_safety_zones import lapid_pkg::*; #(
    parameter int unsigned ACTUATOR_LEN_UM = DEF_ACTUATOR_LEN_UM,
    parameter int unsigned EMERGENCY_UM    = DEF_EMERGENCY_UM,
    parameter int unsigned SAFE_UM         = DEF_SAFE_UM,
    parameter int unsigned SAFE_DUTY       = DEF_SAFE_DUTY,
    parameter int unsigned SLEW_PER_MS     = DEF_SLEW_PER_MS,
    parameter int unsigned TOLERANCE_UM    = DEF_TOLERANCE_UM
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    lapid_in_if.sink              in_ch,
    lapid_out_if.source           out_ch
);

    localparam logic [POS_W-1:0]         LEN_P   = POS_W'(ACTUATOR_LEN_UM);
    localparam logic [POS_W-1:0]         EMG_LO  = POS_W'(EMERGENCY_UM);
    localparam logic [POS_W-1:0]         SAFE_LO = POS_W'(SAFE_UM);
    localparam logic signed [DIF_W-1:0]  EMG_HI  =
        DIF_W'(int'(ACTUATOR_LEN_UM) - int'(EMERGENCY_UM));
    localparam logic signed [DIF_W-1:0]  SAFE_HI =
        DIF_W'(int'(ACTUATOR_LEN_UM) - int'(SAFE_UM));
    localparam logic signed [ERR_W-1:0]  TOL_P   = ERR_W'(TOLERANCE_UM);
    localparam logic signed [DUTY_W-1:0] SDUTY_P = DUTY_W'(SAFE_DUTY);
    localparam logic [31:0]              SLEW_P  = 32'(SLEW_PER_MS);

    // configuration
    logic [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [LIM_W-1:0]  ilim_reg;
    logic [RAW_W-1:0]  raw_min_reg, raw_max_reg;
    logic [PER_W-1:0]  period_reg;
    logic [MS_W-1:0]   lost_reg;

    // control state
    state_t                    state_reg, state_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      pos_vld_reg, pos_vld_next;
    logic [POS_W-1:0]          tgt_pos_reg, tgt_pos_next;
    logic                      tgt_vld_reg, tgt_vld_next;
    logic                      trav_ext_reg, trav_ext_next;
    logic signed [INT_W-1:0]   integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [DUTY_W-1:0]  duty_reg, duty_next;
    logic [CAP_W-1:0]          cap_reg, cap_next;
    logic [MS_W-1:0]           ms_smp_reg, ms_smp_next;
    logic [MS_W-1:0]           ms_upd_reg, ms_upd_next;
    logic [STAT_W-1:0]         stat_reg, stat_next;
    logic                      halted_reg, halted_next;
    logic                      out_vld_reg, out_vld_next;

    // working registers
    logic [RAW_W-1:0]          diff_reg, diff_next;
    logic [MS_W-1:0]           dt_reg, dt_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [31:0]               step_reg, step_next;
    logic                      dneg_reg, dneg_next;
    logic signed [DRV_W-1:0]   deriv_reg, deriv_next;
    logic signed [MUL_P_W-1:0] acc_reg, acc_next;
    logic signed [DUTY_W-1:0]  tgt_reg, tgt_next;
    logic signed [DUTY_W-1:0]  o_duty_reg;
    logic                      o_ext_reg, o_ret_reg;
    logic [STAT_W-1:0]         o_stat_reg;

    mul_req_t                  mreq;
    logic signed [MUL_P_W-1:0] prod;
    div_req_t                  dreq;
    div_rsp_t                  drsp;

    // combinational helpers
    logic                      accept;
    logic [MS_W-1:0]           smp_inc, upd_inc;
    logic signed [ERR_W-1:0]   err_now;
    logic signed [ERR_W:0]     t_ext;
    logic [POS_W-1:0]          t_clamp;
    logic signed [DIF_W-1:0]   dif_now;
    logic signed [SUM_W-1:0]   isum, ilim_s;
    logic signed [MUL_P_W-1:0] acc_adj;
    logic signed [TGT_W-1:0]   tw, cap_w;
    logic signed [DUTY_W-1:0]  t2;
    logic signed [33:0]        vs;
    logic signed [DIF_W-1:0]   pos_s;

    lapid_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    lapid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        pos_vld_next  = pos_vld_reg;
        tgt_pos_next  = tgt_pos_reg;
        tgt_vld_next  = tgt_vld_reg;
        trav_ext_next = trav_ext_reg;
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        duty_next     = duty_reg;
        cap_next      = cap_reg;
        ms_smp_next   = ms_smp_reg;
        ms_upd_next   = ms_upd_reg;
        stat_next     = stat_reg;
        halted_next   = halted_reg;
        out_vld_next  = out_vld_reg;
        diff_next     = diff_reg;
        dt_next       = dt_reg;
        err_next      = err_reg;
        step_next     = step_reg;
        dneg_next     = dneg_reg;
        deriv_next    = deriv_reg;
        acc_next      = acc_reg;
        tgt_next      = tgt_reg;

        mreq.en = 1'b0;
        mreq.a  = '0;
        mreq.b  = '0;
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;

        smp_inc = (ms_smp_reg == '1) ? ms_smp_reg : ms_smp_reg + 1'b1;
        upd_inc = (ms_upd_reg == '1) ? ms_upd_reg : ms_upd_reg + 1'b1;
        err_now = $signed({1'b0, tgt_pos_reg}) - $signed({1'b0, pos_reg});
        t_ext   = {in_ch.target_um[ERR_W-1], in_ch.target_um};
        if (in_ch.target_um[ERR_W-1])
        begin
            t_clamp = '0;
        end
        else if (t_ext > $signed({2'b0, LEN_P}))
        begin
            t_clamp = LEN_P;
        end
        else
        begin
            t_clamp = in_ch.target_um[POS_W-1:0];
        end
        dif_now = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};
        isum    = SUM_W'(integ_reg) + prod[SUM_W-1:0];
        ilim_s  = $signed({{(SUM_W-LIM_W){1'b0}}, ilim_reg});
        acc_adj = acc_reg + (acc_reg[MUL_P_W-1] ? MUL_P_W'(65535) : MUL_P_W'(0));
        tw      = acc_adj[MUL_P_W-1:16];
        cap_w   = $signed({{(TGT_W-CAP_W){1'b0}}, cap_reg});
        pos_s   = $signed({2'b0, pos_reg});
        t2      = tgt_reg;
        vs      = '0;

        if (out_ch.valid && out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EMIT;
                    case (cmd_t'(in_ch.cmd))
                        CMD_SAMPLE:
                        begin
                            pos_vld_next = 1'b1;
                            ms_smp_next  = '0;
                            diff_next    = in_ch.raw_sample - raw_min_reg;
                            if (in_ch.raw_sample < raw_min_reg)
                            begin
                                pos_next = '0;
                            end
                            else if (in_ch.raw_sample > raw_max_reg)
                            begin
                                pos_next = LEN_P;
                            end
                            else if (raw_max_reg == raw_min_reg)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                state_next = S_SMP_MUL;
                            end
                        end
                        CMD_MOVE:
                        begin
                            cap_next = (in_ch.power_limit > {1'b0, CAP_MAX}) ?
                                       CAP_MAX : in_ch.power_limit[CAP_W-1:0];
                            tgt_pos_next = t_clamp;
                            tgt_vld_next = 1'b1;
                            if ((t_clamp > pos_reg) != trav_ext_reg)
                            begin
                                trav_ext_next = t_clamp > pos_reg;
                                integ_next    = '0;
                                prev_err_next = $signed({1'b0, t_clamp})
                                              - $signed({1'b0, pos_reg});
                            end
                        end
                        CMD_TICK:
                        begin
                            ms_smp_next = smp_inc;
                            ms_upd_next = upd_inc;
                            if (smp_inc > lost_reg)
                            begin
                                pos_vld_next = 1'b0;
                                duty_next    = '0;
                                halted_next  = 1'b1;
                                stat_next    = ST_LOST;
                            end
                            else if (!pos_vld_reg || !tgt_vld_reg)
                            begin
                                duty_next   = '0;
                                halted_next = 1'b1;
                                stat_next   = ST_STOPPED;
                            end
                            else
                            begin
                                stat_next = ST_OK;
                                if (upd_inc >= {{(MS_W-PER_W){1'b0}}, period_reg})
                                begin
                                    dt_next     = upd_inc;
                                    ms_upd_next = '0;
                                    err_next    = err_now;
                                    state_next  = S_T_IMUL;
                                end
                            end
                        end
                        default:
                        begin
                            duty_next    = '0;
                            halted_next  = 1'b1;
                            tgt_pos_next = pos_reg;
                            tgt_vld_next = pos_vld_reg;
                        end
                    endcase
                end
            end
            S_SMP_MUL:
            begin
                mreq.en    = 1'b1;
                mreq.a     = $signed({{(MUL_A_W-RAW_W){1'b0}}, diff_reg});
                mreq.b     = $signed({{(MUL_B_W-POS_W){1'b0}}, LEN_P});
                state_next = S_SMP_DIV;
            end
            S_SMP_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = prod[DIV_N_W-1:0];
                dreq.den   = raw_max_reg - raw_min_reg;
                state_next = S_SMP_WAIT;
            end
            S_SMP_WAIT:
            begin
                if (drsp.done)
                begin
                    pos_next   = drsp.quot[POS_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_T_IMUL:
            begin
                mreq.en    = 1'b1;
                mreq.a     = $signed({{(MUL_A_W-MS_W){1'b0}}, dt_reg});
                mreq.b     = MUL_B_W'(err_reg);
                step_next  = SLEW_P * {16'b0, dt_reg};
                state_next = S_T_INT;
            end
            S_T_INT:
            begin
                if (err_reg > 0 && !trav_ext_reg)
                begin
                    integ_next    = '0;
                    trav_ext_next = 1'b1;
                end
                else if (err_reg < 0 && trav_ext_reg)
                begin
                    integ_next    = '0;
                    trav_ext_next = 1'b0;
                end
                else if (isum < -ilim_s)
                begin
                    integ_next = INT_W'(-ilim_s);
                end
                else if (isum > ilim_s)
                begin
                    integ_next = INT_W'(ilim_s);
                end
                else
                begin
                    integ_next = isum[INT_W-1:0];
                end
                dneg_next     = dif_now[DIF_W-1];
                prev_err_next = err_reg;
                dreq.start    = 1'b1;
                dreq.num      = {{(DIV_N_W-DIF_W){1'b0}},
                                 (dif_now[DIF_W-1] ? DIF_W'(-dif_now) : dif_now)};
                dreq.den      = dt_reg;
                mreq.en       = 1'b1;
                mreq.a        = $signed({1'b0, kp_reg});
                mreq.b        = MUL_B_W'(err_reg);
                state_next    = S_T_P;
            end
            S_T_P:
            begin
                acc_next   = prod;
                mreq.en    = 1'b1;
                mreq.a     = $signed({1'b0, ki_reg});
                mreq.b     = MUL_B_W'(integ_reg);
                state_next = S_T_I;
            end
            S_T_I:
            begin
                acc_next   = acc_reg + prod;
                state_next = S_T_DWAIT;
            end
            S_T_DWAIT:
            begin
                if (drsp.done)
                begin
                    deriv_next = dneg_reg ? -$signed({1'b0, drsp.quot[DIF_W-1:0]})
                                          : $signed({1'b0, drsp.quot[DIF_W-1:0]});
                    state_next = S_T_DMUL;
                end
            end
            S_T_DMUL:
            begin
                mreq.en    = 1'b1;
                mreq.a     = $signed({1'b0, kd_reg});
                mreq.b     = MUL_B_W'(deriv_reg);
                state_next = S_T_D;
            end
            S_T_D:
            begin
                acc_next   = acc_reg + prod;
                state_next = S_T_FIN;
            end
            S_T_FIN:
            begin
                if (err_reg < TOL_P && err_reg > -TOL_P)
                begin
                    tgt_next = '0;
                end
                else if (tw > cap_w)
                begin
                    tgt_next = DUTY_W'(cap_w);
                end
                else if (tw < -cap_w)
                begin
                    tgt_next = DUTY_W'(-cap_w);
                end
                else
                begin
                    tgt_next = tw[DUTY_W-1:0];
                end
                state_next = S_T_OUT;
            end
            S_T_OUT:
            begin
                state_next = S_EMIT;
                if ((pos_reg < EMG_LO && tgt_reg < 0) || (pos_s > EMG_HI && tgt_reg > 0))
                begin
                    duty_next   = '0;
                    halted_next = 1'b1;
                    stat_next   = ST_EMERGENCY;
                end
                else
                begin
                    if (pos_reg < SAFE_LO && tgt_reg < 0)
                    begin
                        stat_next = ST_SAFE;
                        if (tgt_reg < -SDUTY_P)
                        begin
                            t2 = -SDUTY_P;
                        end
                    end
                    if (pos_s > SAFE_HI && tgt_reg > 0)
                    begin
                        stat_next = ST_SAFE;
                        if (tgt_reg > SDUTY_P)
                        begin
                            t2 = SDUTY_P;
                        end
                    end
                    if (duty_reg > t2)
                    begin
                        vs = 34'(duty_reg) - $signed({2'b0, step_reg});
                        duty_next = (vs < 34'(t2)) ? t2 : vs[DUTY_W-1:0];
                    end
                    else
                    begin
                        vs = 34'(duty_reg) + $signed({2'b0, step_reg});
                        duty_next = (vs > 34'(t2)) ? t2 : vs[DUTY_W-1:0];
                    end
                    halted_next = 1'b0;
                end
            end
            S_EMIT:
            begin
                if (!out_vld_reg || out_ch.ready)
                begin
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= GAIN_W'(1311);
            ki_reg       <= GAIN_W'(1);
            kd_reg       <= '0;
            ilim_reg     <= LIM_W'(50000);
            raw_min_reg  <= '0;
            raw_max_reg  <= '1;
            period_reg   <= PER_W'(10);
            lost_reg     <= MS_W'(100);
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            pos_vld_reg  <= 1'b0;
            tgt_pos_reg  <= '0;
            tgt_vld_reg  <= 1'b0;
            trav_ext_reg <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            duty_reg     <= '0;
            cap_reg      <= CAP_MAX;
            ms_smp_reg   <= '1;
            ms_upd_reg   <= '0;
            stat_reg     <= ST_OK;
            halted_reg   <= 1'b1;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_KP:      kp_reg      <= cfg_data[GAIN_W-1:0];
                    REG_KI:      ki_reg      <= cfg_data[GAIN_W-1:0];
                    REG_KD:      kd_reg      <= cfg_data[GAIN_W-1:0];
                    REG_ILIM:    ilim_reg    <= cfg_data[LIM_W-1:0];
                    REG_RAW_MIN: raw_min_reg <= cfg_data[RAW_W-1:0];
                    REG_RAW_MAX: raw_max_reg <= cfg_data[RAW_W-1:0];
                    REG_PERIOD:  period_reg  <= cfg_data[PER_W-1:0];
                    default:     lost_reg    <= cfg_data[MS_W-1:0];
                endcase
            end
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            pos_vld_reg  <= pos_vld_next;
            tgt_pos_reg  <= tgt_pos_next;
            tgt_vld_reg  <= tgt_vld_next;
            trav_ext_reg <= trav_ext_next;
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            duty_reg     <= duty_next;
            cap_reg      <= cap_next;
            ms_smp_reg   <= ms_smp_next;
            ms_upd_reg   <= ms_upd_next;
            stat_reg     <= stat_next;
            halted_reg   <= halted_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        dt_reg    <= dt_next;
        err_reg   <= err_next;
        step_reg  <= step_next;
        dneg_reg  <= dneg_next;
        deriv_reg <= deriv_next;
        acc_reg   <= acc_next;
        tgt_reg   <= tgt_next;
        if (state_reg == S_EMIT && (!out_vld_reg || out_ch.ready))
        begin
            o_duty_reg <= duty_reg;
            o_ext_reg  <= !halted_reg && duty_reg > 0;
            o_ret_reg  <= !halted_reg && duty_reg <= 0;
            o_stat_reg <= stat_reg;
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.duty        = o_duty_reg;
    assign out_ch.dir_extend  = o_ext_reg;
    assign out_ch.dir_retract = o_ret_reg;
    assign out_ch.status      = o_stat_reg;

endmodule

`default_nettype wire

@@ rtl/lapid_mul.sv @@
// ----------------------------------------------------------------------------
// lapid_mul
// Shared signed multiplier, product registered when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module lapid_mul import lapid_pkg::*; (
    input  wire logic                      clk,
    input  wire mul_req_t                  req,
    output logic signed [MUL_P_W-1:0]      prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/lapid_div.sv @@
// ----------------------------------------------------------------------------
// lapid_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lapid_div import lapid_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_N_W-1:0] quot_reg, quot_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, quot_reg[DIV_N_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_N_W - 1);
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next  = rem_sub[DIV_D_W-1:0];
                quot_next = {quot_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DIV_D_W-1:0];
                quot_next = {quot_reg[DIV_N_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

@@ rtl/lapid_checker.sv @@
// ----------------------------------------------------------------------------
// lapid_checker
// Port-level checks on result beats of the actuator controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lapid_checker import lapid_pkg::*; (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [DUTY_W-1:0] duty,
    input wire logic                     dir_extend,
    input wire logic                     dir_retract,
    input wire logic [STAT_W-1:0]        status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(status))
        else $error("result beat changed while stalled");

    a_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dir_extend && dir_retract) && (!dir_extend || duty > 0)
                      && (!dir_retract || duty <= 0))
        else $error("direction pins disagree with duty");

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_LOST || status == ST_STOPPED || status == ST_EMERGENCY)
        |-> duty == 0 && !dir_extend && !dir_retract)
        else $error("drive active in a halted status");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty <= 16'sd31785 && duty >= -16'sd31785)
        else $error("duty beyond cap");

endmodule

bind linear_actuator_pid_with_safety_zones lapid_checker u_lapid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .duty        (out_ch.duty),
    .dir_extend  (out_ch.dir_extend),
    .dir_retract (out_ch.dir_retract),
    .status      (out_ch.status)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the actuator PID: predicts each result beat from its
// own model of the loop, across several register settings and random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lapid_pkg::*;

    localparam longint LEN = DEF_ACTUATOR_LEN_UM;
    localparam longint EMG = DEF_EMERGENCY_UM;
    localparam longint SAFEZ = DEF_SAFE_UM;
    localparam longint SAFED = DEF_SAFE_DUTY;
    localparam longint SLEW = DEF_SLEW_PER_MS;
    localparam longint TOL = DEF_TOLERANCE_UM;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [DUTY_W-1:0] duty;
        logic                     ext;
        logic                     ret;
        logic [STAT_W-1:0]        status;
    } drive_t;

    class pid_scoreboard;
        longint kp, ki, kd, ilim, rmin, rmax, period, lost;
        longint pos, tgt, integ, perr, duty, cap;
        bit     pos_ok, tgt_ok, extending, halted;
        int unsigned ms_smp, ms_upd;
        status_t stat;
        drive_t  pending[$];
        int      errors;
        int      results;

        function new();
            kp = 1311; ki = 1; kd = 0; ilim = 50000;
            rmin = 0; rmax = 65535; period = 10; lost = 100;
            pos = 0; tgt = 0; integ = 0; perr = 0; duty = 0; cap = CAP_MAX;
            pos_ok = 0; tgt_ok = 0; extending = 0; halted = 1;
            ms_smp = 65535; ms_upd = 0; stat = ST_OK;
            errors = 0; results = 0;
        endfunction

        function void set_reg(reg_idx_t idx, longint v);
            case (idx)
                REG_KP:      kp = v;
                REG_KI:      ki = v;
                REG_KD:      kd = v;
                REG_ILIM:    ilim = v;
                REG_RAW_MIN: rmin = v;
                REG_RAW_MAX: rmax = v;
                REG_PERIOD:  period = v;
                default:     lost = v;
            endcase
        endfunction

        function void halt(status_t s);
            duty = 0;
            halted = 1;
            stat = s;
        endfunction

        function void control_tick();
            longint dt, err, sum, t, step, v;
            if (ms_smp < 65535) ms_smp++;
            if (ms_upd < 65535) ms_upd++;
            if (ms_smp > lost) begin
                pos_ok = 0;
                halt(ST_LOST);
                return;
            end
            if (!pos_ok || !tgt_ok) begin
                halt(ST_STOPPED);
                return;
            end
            stat = ST_OK;
            if (ms_upd < period) return;
            dt = ms_upd;
            ms_upd = 0;
            err = tgt - pos;
            if (err > 0 && !extending) begin
                integ = 0;
                extending = 1;
            end
            else if (err < 0 && extending) begin
                integ = 0;
                extending = 0;
            end
            else begin
                integ += err * dt;
                if (integ < -ilim) integ = -ilim;
                if (integ > ilim) integ = ilim;
            end
            sum = kp * err + ki * integ + kd * ((err - perr) / dt);
            t = sum / 65536;
            perr = err;
            if (err < TOL && err > -TOL) t = 0;
            if (t > cap) t = cap;
            if (t < -cap) t = -cap;
            if ((pos < EMG && t < 0) || (pos > LEN - EMG && t > 0)) begin
                halt(ST_EMERGENCY);
                return;
            end
            if (pos < SAFEZ && t < 0) begin
                stat = ST_SAFE;
                if (t < -SAFED) t = -SAFED;
            end
            if (pos > LEN - SAFEZ && t > 0) begin
                stat = ST_SAFE;
                if (t > SAFED) t = SAFED;
            end
            step = SLEW * dt;
            if (duty > t) begin
                v = duty - step;
                duty = (v < t) ? t : v;
            end
            else begin
                v = duty + step;
                duty = (v > t) ? t : v;
            end
            halted = 0;
        endfunction

        function void note_beat(cmd_t c, logic [15:0] raw, logic signed [ERR_W-1:0] tu,
                                logic [15:0] pwr);
            longint t;
            drive_t d;
            bit ext;
            case (c)
                CMD_SAMPLE:
                begin
                    if (raw < rmin) pos = 0;
                    else if (raw > rmax) pos = LEN;
                    else if (rmax == rmin) pos = 0;
                    else pos = (LEN * (longint'(raw) - rmin)) / (rmax - rmin);
                    pos_ok = 1;
                    ms_smp = 0;
                end
                CMD_MOVE:
                begin
                    t = tu;
                    cap = (pwr > CAP_MAX) ? CAP_MAX : pwr;
                    if (t > LEN) t = LEN;
                    if (t < 0) t = 0;
                    ext = t > pos;
                    tgt = t;
                    tgt_ok = 1;
                    if (ext != extending) begin
                        extending = ext;
                        integ = 0;
                        perr = t - pos;
                    end
                end
                CMD_TICK:
                    control_tick();
                default:
                begin
                    duty = 0;
                    halted = 1;
                    tgt = pos;
                    tgt_ok = pos_ok;
                end
            endcase
            d.duty = duty[DUTY_W-1:0];
            d.ext = !halted && duty > 0;
            d.ret = !halted && duty <= 0;
            d.status = stat;
            pending.push_back(d);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(drive_t got);
            drive_t want;
            results++;
            if (pending.size() == 0) begin
                report("result beat with nothing pending");
                return;
            end
            want = pending.pop_front();
            if (got.duty !== want.duty)
                report($sformatf("duty %0d, want %0d", got.duty, want.duty));
            if (got.ext !== want.ext)
                report($sformatf("dir_extend %b, want %b", got.ext, want.ext));
            if (got.ret !== want.ret)
                report($sformatf("dir_retract %b, want %b", got.ret, want.ret));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lapid_in_if  in_ch();
    lapid_out_if out_ch();

    linear_actuator_pid_with_safety_zones u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    pid_scoreboard sb = new();
    int burst_left = 0;
    int items_sent = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    int stall_mode = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: stall pattern is picked anew at random moments
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = ($urandom_range(0, 1) == 0);
            2: out_ch.ready = ($urandom_range(0, 7) == 0);
            default: out_ch.ready = ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.duty, out_ch.dir_extend, out_ch.dir_retract,
                             out_ch.status});
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send(cmd_t c, logic [15:0] raw, logic signed [ERR_W-1:0] tu,
                        logic [15:0] pwr);
        @(negedge clk);
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid = 1'b1;
        in_ch.cmd = c;
        in_ch.raw_sample = raw;
        in_ch.target_um = tu;
        in_ch.power_limit = pwr;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_beat(c, raw, tu, pwr);
        burst_left--;
        items_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(reg_idx_t idx, longint v);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(v);
        sb.set_reg(idx, v);
        cfg_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic rand_beat();
        send(cmd_t'($urandom_range(0, 3)), 16'($urandom), ERR_W'($urandom),
             16'($urandom));
    endtask

    // sample, move, then a run of ticks and fresh samples with the odd move, stop or random beat
    task automatic control_run(int n);
        int i;
        int k;
        logic [15:0] raw;
        longint t;
        raw = 16'($urandom);
        send(CMD_SAMPLE, raw, '0, '0);
        send(CMD_MOVE, '0, ERR_W'($urandom_range(0, 200000)), 16'($urandom));
        for (i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 52)
                send(CMD_TICK, '0, '0, '0);
            else if (k < 88) begin
                if ($urandom_range(0, 3) == 0) raw = 16'($urandom);
                else raw = 16'(int'(raw) + $urandom_range(0, 2000) - 1000);
                send(CMD_SAMPLE, raw, '0, '0);
            end
            else if (k < 94) begin
                if ($urandom_range(0, 1)) t = sb.pos + $urandom_range(0, 600) - 300;
                else t = $urandom_range(0, 210000) - 5000;
                send(CMD_MOVE, '0, ERR_W'(t), 16'($urandom));
            end
            else if (k < 96)
                send(CMD_STOP, '0, '0, '0);
            else
                rand_beat();
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_SAMPLE;
        in_ch.raw_sample = '0;
        in_ch.target_um = '0;
        in_ch.power_limit = '0;
        out_ch.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        send(CMD_TICK, '0, '0, '0);
        send(CMD_STOP, '0, '0, '0);
        send(CMD_SAMPLE, 16'd0, '0, '0);
        send(CMD_TICK, '0, '0, '0);
        send(CMD_MOVE, '0, 19'sh40000, 16'hFFFF);
        send(CMD_SAMPLE, 16'hFFFF, '0, '0);
        send(CMD_MOVE, '0, 19'sd262143, 16'd0);
        send(CMD_MOVE, '0, 19'sd262143, 16'd31786);
        repeat (10) send(CMD_TICK, '0, '0, '0);
        send(CMD_SAMPLE, 16'd1000, '0, '0);
        send(CMD_MOVE, '0, 19'sd3050, 16'd20000);
        repeat (3) send(CMD_TICK, '0, '0, '0);
        send(CMD_STOP, '0, '0, '0);
        send(CMD_TICK, '0, '0, '0);
        drain();

        // fast loop, strong gains
        write_reg(REG_PERIOD, 1);
        write_reg(REG_KP, 40000);
        write_reg(REG_KI, 50);
        write_reg(REG_KD, 20000);
        control_run(140);
        drain();

        // extreme gains and integral limit
        write_reg(REG_KP, 24'hFFFFFF);
        write_reg(REG_KI, 24'hFFFFFF);
        write_reg(REG_KD, 24'hFFFFFF);
        write_reg(REG_ILIM, 31'h7FFFFFFF);
        write_reg(REG_PERIOD, 3);
        control_run(140);
        drain();

        // zero gains, short sensor timeout
        write_reg(REG_KP, 0);
        write_reg(REG_KI, 0);
        write_reg(REG_KD, 0);
        write_reg(REG_ILIM, 0);
        write_reg(REG_LOST, 1);
        write_reg(REG_PERIOD, 1);
        control_run(120);
        drain();

        // narrow raw span
        write_reg(REG_KP, 3000);
        write_reg(REG_KI, 4);
        write_reg(REG_ILIM, 200000);
        write_reg(REG_RAW_MIN, 20000);
        write_reg(REG_RAW_MAX, 40000);
        write_reg(REG_LOST, 65535);
        write_reg(REG_PERIOD, 2);
        control_run(140);
        drain();

        // inverted and equal raw bounds
        write_reg(REG_RAW_MIN, 50000);
        write_reg(REG_RAW_MAX, 10000);
        control_run(60);
        drain();
        write_reg(REG_RAW_MIN, 30000);
        write_reg(REG_RAW_MAX, 30000);
        send(CMD_SAMPLE, 16'd30000, '0, '0);
        control_run(60);
        drain();

        // longest period used by the bench
        write_reg(REG_RAW_MIN, 0);
        write_reg(REG_RAW_MAX, 65535);
        write_reg(REG_PERIOD, 1000);
        write_reg(REG_LOST, 2000);
        control_run(90);
        drain();

        // default-like settings, plus noise
        write_reg(REG_KP, 1311);
        write_reg(REG_KI, 1);
        write_reg(REG_KD, 500);
        write_reg(REG_ILIM, 50000);
        write_reg(REG_PERIOD, 10);
        write_reg(REG_LOST, 100);
        control_run(150);
        repeat (150) rand_beat();

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d command beats, %0d result beats, %0d register writes",
                 items_sent, sb.results, cfg_writes);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/lapid_pkg.sv
rtl/lapid_if.sv
rtl/lapid_mul.sv
rtl/lapid_div.sv
rtl/linear_actuator_pid_with_safety_zones.sv
rtl/lapid_checker.sv
tb/testbench.sv
